### hdl/phw_pkg.sv
package phw_pkg;

  localparam int NATO_COUNT  = 26;
  localparam int NATO_MAXLEN = 8;

  // Spelling words, right-justified: the first letter sits in the highest used byte
  localparam logic [63:0] NATO_WORDS [NATO_COUNT] = '{
    64'("alfa"), 64'("bravo"), 64'("charlie"), 64'("delta"), 64'("echo"),
    64'("foxtrot"), 64'("golf"), 64'("hotel"), 64'("india"), 64'("juliett"),
    64'("kilo"), 64'("lima"), 64'("mike"), 64'("november"), 64'("oscar"),
    64'("papa"), 64'("quebec"), 64'("romeo"), 64'("sierra"), 64'("tango"),
    64'("uniform"), 64'("victor"), 64'("whiskey"), 64'("xray"), 64'("yankee"),
    64'("zulu")
  };

  localparam logic [3:0] NATO_LEN [NATO_COUNT] = '{
    4'd4, 4'd5, 4'd7, 4'd5, 4'd4, 4'd7, 4'd4, 4'd5, 4'd5, 4'd7,
    4'd4, 4'd4, 4'd4, 4'd8, 4'd5, 4'd4, 4'd6, 4'd5, 4'd6, 4'd5,
    4'd7, 4'd6, 4'd7, 4'd4, 4'd6, 4'd4
  };

  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [6:0] UPPER_A     = 7'h41;
  localparam logic [NATO_COUNT-1:0] ALL_WORDS = '1;

  // Match tracking state carried between bytes
  typedef struct packed {
    logic [NATO_COUNT-1:0] alive;
    logic [NATO_COUNT-1:0] hit;
    logic                  stopped;
  } phw_masks_t;

  // One result from the per-byte step
  typedef struct packed {
    logic       fire;
    logic [6:0] letter;
    logic       matched;
    logic       overflow;
  } phw_result_t;

  // Lower-case character at position p of word w, 0 past the end
  function automatic logic [7:0] nato_char(input int w, input logic [2:0] p);
    logic [3:0] len;
    logic [2:0] idx;
    len = NATO_LEN[w];
    idx = 3'(len - 4'd1 - {1'b0, p});
    if ({1'b0, p} >= len) begin
      return 8'h00;
    end
    return NATO_WORDS[w][{idx, 3'b000} +: 8];
  endfunction

endpackage

### hdl/phonetic_word_decoder.sv
// Phonetic word decoder: reads a text stream one byte per item on the input
// channel (in_valid/in_ready, in_byte) and reports each finished word on the
// output channel (out_valid/out_ready, letter, matched, overflow).
// Letters build a word; any other byte ends a non-empty word, which yields one
// item: the upper-case initial of the spelling word it begins with, or 0.
// A word reaching MAX_WORD letters yields an overflow item, after which all
// input is taken and dropped until reset.
// Timing: a byte is registered in the input register on acceptance, and its
// result moves to the output register once that register is free.
// Throughput: one byte per cycle unless the receiver stalls; the mask update
// and priority pick fit in the single stage between the input and output registers.
// Reset (rst, synchronous) empties both registers and starts a fresh word.
// When the receiver stalls, the output register holds its item, the input
// register still takes one more byte if it is empty, then in_ready drops until out_ready.
module phonetic_word_decoder #(
  parameter int MAX_WORD = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] letter,
  output logic       matched,
  output logic       overflow
);
  import phw_pkg::*;

  localparam int CNT_W = $clog2(MAX_WORD + 1);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  phw_masks_t       masks;
  phw_masks_t       masks_next;
  phw_result_t      result;
  logic             res_free;
  logic             s1_fire;

  assign res_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && res_free;
  assign in_ready = !s1_valid || res_free;

  phw_step #(
    .MAX_WORD (MAX_WORD),
    .CNT_W    (CNT_W)
  ) u_step (
    .in_byte    (s1_byte),
    .count      (count),
    .masks      (masks),
    .count_next (count_next),
    .masks_next (masks_next),
    .result     (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  // Word tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      masks <= '{alive: ALL_WORDS, hit: '0, stopped: 1'b0};
    end else if (s1_fire) begin
      count <= count_next;
      masks <= masks_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= result.fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && result.fire) begin
      letter   <= result.letter;
      matched  <= result.matched;
      overflow <= result.overflow;
    end
  end

`ifndef SYNTHESIS
  // An overflow item carries no match
  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !matched && letter == 7'd0)
    else $error("overflow item carries a match");

  // Match flag agrees with the initial
  a_match_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> matched == (letter != 7'd0))
    else $error("matched flag and letter disagree");

  // Nothing follows a delivered overflow
  a_stop_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && overflow |=> !out_valid)
    else $error("item after overflow");

  // A word only counts as hit while it is still alive
  a_hit_alive: assert property (@(posedge clk) disable iff (rst)
    (masks.hit & ~masks.alive) == '0)
    else $error("hit word not alive");
`endif

endmodule

### hdl/phw_step.sv
module phw_step #(
  parameter int MAX_WORD = 64,
  parameter int CNT_W    = $clog2(MAX_WORD + 1)
) (
  input  logic [7:0]         in_byte,
  input  logic [CNT_W-1:0]   count,
  input  phw_pkg::phw_masks_t  masks,
  output logic [CNT_W-1:0]   count_next,
  output phw_pkg::phw_masks_t  masks_next,
  output phw_pkg::phw_result_t result
);
  import phw_pkg::*;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_WORD - 1);

  logic       is_letter;
  logic [7:0] low;
  logic       pos_ok;
  logic [2:0] pos;
  logic [3:0] pos_len;
  logic [6:0] first_letter;
  logic       any_hit;

  assign is_letter = (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                     (in_byte >= 8'h61 && in_byte <= 8'h7A);
  assign low       = in_byte | CASE_BIT;
  assign pos_ok    = count < CNT_W'(NATO_MAXLEN);
  assign pos       = count[2:0];
  assign pos_len   = {1'b0, pos} + 4'd1;

  // Lowest hit word gives the initial
  always_comb begin
    first_letter = '0;
    any_hit      = 1'b0;
    for (int w = NATO_COUNT - 1; w >= 0; w--) begin
      if (masks.hit[w]) begin
        first_letter = UPPER_A + 7'(w);
        any_hit      = 1'b1;
      end
    end
  end

  // Per-byte update
  always_comb begin
    count_next = count;
    masks_next = masks;
    result     = '0;
    if (!masks.stopped) begin
      if (is_letter) begin
        for (int w = 0; w < NATO_COUNT; w++) begin
          if (masks.alive[w] && !masks.hit[w]) begin
            if (pos_ok && nato_char(w, pos) == low) begin
              if (pos_len == NATO_LEN[w]) begin
                masks_next.hit[w] = 1'b1;
              end
            end else begin
              masks_next.alive[w] = 1'b0;
            end
          end
        end
        count_next = count + CNT_W'(1);
        if (count == LAST_POS) begin
          masks_next.stopped = 1'b1;
          result.fire        = 1'b1;
          result.overflow    = 1'b1;
        end
      end else if (count != '0) begin
        result.fire    = 1'b1;
        result.letter  = first_letter;
        result.matched = any_hit;
        count_next     = '0;
        masks_next.alive = ALL_WORDS;
        masks_next.hit   = '0;
      end
    end
  end

endmodule
